// ----- rtl/spq_pkg.sv -----
// Package with the item types, status codes and field widths of the sorted priority queue.
package spq_pkg;

	// Field widths of one request item and one response item.
	localparam int TAG_W  = 16;
	localparam int PRIO_W = 16;
	localparam int OCC_W  = 5;

	// Operation codes carried by a request item.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Status codes carried by a response item.
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One request item.
	typedef struct packed {
		op_t                      operation;
		logic [TAG_W-1:0]         task_tag;
		logic signed [PRIO_W-1:0] priority_req;
	} req_item_t;

	// One response item.
	typedef struct packed {
		status_t                  status;
		logic [TAG_W-1:0]         removed_tag;
		logic signed [PRIO_W-1:0] removed_priority;
		logic [OCC_W-1:0]         occupancy;
	} rsp_item_t;

	// Per-cell load controls; at most one is set in a cycle.
	typedef struct packed {
		logic load_new;
		logic from_prev;
		logic from_next;
	} cell_ctl_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of entry cells with a response register.
//
// The block keeps up to DEPTH entries in descending priority order, newest
// first among equal priorities. A request item either inserts a tag with a
// signed priority or removes the head entry. Each request yields exactly one
// response item carrying a status, the removed tag and priority (zero unless
// an entry was removed) and the occupancy after the operation.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low.
// Every cell compares its entry with the new priority in parallel and loads
// the new entry, its upper neighbor or its lower neighbor. The response
// appears in the output register in the cycle after the request is
// accepted, and one request per cycle is accepted while the receiver takes
// responses.
// When the receiver stalls, the response register holds its item and
// req_stall rises until that item is taken; the queue contents do not move.
// Reset empties the queue and the response register; cell contents are left
// as they are and are never read while the cell is outside the occupancy.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_q;
	rsp_item_t                rsp_next;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     do_ins;
	logic                     do_rem;
	logic [DEPTH-1:0]         place;
	cell_ctl_t                ctl [DEPTH];
	logic [TAG_W-1:0]         tag_c [DEPTH];
	logic signed [PRIO_W-1:0] prio_c [DEPTH];

	// Handshake and operation decode.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_ins    = accept && (req.operation == OP_INSERT) && !full;
	assign do_rem    = accept && (req.operation == OP_REMOVE) && !empty;

	// Cell chain with per-cell load controls.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TAG_W-1:0]         prev_tag;
		logic signed [PRIO_W-1:0] prev_prio;
		logic [TAG_W-1:0]         next_tag;
		logic signed [PRIO_W-1:0] next_prio;
		logic                     prev_place;

		if (i == 0) begin : g_first
			assign prev_tag   = '0;
			assign prev_prio  = '0;
			assign prev_place = 1'b0;
		end else begin : g_mid
			assign prev_tag   = tag_c[i-1];
			assign prev_prio  = prio_c[i-1];
			assign prev_place = place[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_tag  = '0;
			assign next_prio = '0;
		end else begin : g_inner
			assign next_tag  = tag_c[i+1];
			assign next_prio = prio_c[i+1];
		end

		// The first placing cell takes the new entry; later ones shift down.
		assign ctl[i].load_new  = do_ins && place[i] && !prev_place;
		assign ctl[i].from_prev = do_ins && prev_place;
		assign ctl[i].from_next = do_rem;

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.occupied  (count_q > CNT_W'(i)),
			.new_tag   (req.task_tag),
			.new_prio  (req.priority_req),
			.prev_tag  (prev_tag),
			.prev_prio (prev_prio),
			.next_tag  (next_tag),
			.next_prio (next_prio),
			.place     (place[i]),
			.tag       (tag_c[i]),
			.prio      (prio_c[i])
		);
	end

	// Occupancy update and response contents.
	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end

		rsp_next                  = '0;
		rsp_next.occupancy        = OCC_W'(count_next);
		if (req.operation == OP_INSERT) begin
			rsp_next.status = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			rsp_next.status = ST_EMPTY;
		end else begin
			rsp_next.status           = ST_REMOVED;
			rsp_next.removed_tag      = tag_c[0];
			rsp_next.removed_priority = prio_c[0];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/spq_cell.sv -----
// One storage cell of the sorted chain: holds an entry and compares it with a new priority.
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     occupied,
	input  logic [TAG_W-1:0]         new_tag,
	input  logic signed [PRIO_W-1:0] new_prio,
	input  logic [TAG_W-1:0]         prev_tag,
	input  logic signed [PRIO_W-1:0] prev_prio,
	input  logic [TAG_W-1:0]         next_tag,
	input  logic signed [PRIO_W-1:0] next_prio,
	output logic                     place,
	output logic [TAG_W-1:0]         tag,
	output logic signed [PRIO_W-1:0] prio
);

	logic [TAG_W-1:0]         tag_q;
	logic signed [PRIO_W-1:0] prio_q;

	// A new entry belongs at or before this cell when the cell is free or holds
	// a priority that is not above the new one.
	assign place = !occupied || (new_prio >= prio_q);

	// Entry storage; the controls pick the new entry or a neighbor's.
	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			tag_q  <= new_tag;
			prio_q <= new_prio;
		end else if (ctl.from_prev) begin
			tag_q  <= prev_tag;
			prio_q <= prev_prio;
		end else if (ctl.from_next) begin
			tag_q  <= next_tag;
			prio_q <= next_prio;
		end
	end

	assign tag  = tag_q;
	assign prio = prio_q;

endmodule

// ----- rtl/spq_chk.sv -----
// Port checker for the sorted priority queue and its bind to the top level.
module spq_chk
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_item_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// A stalled request item stays valid and unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request item changed or dropped");

	// A stalled response item stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response item changed or dropped");

	// Every accepted request item gives a response item in the next cycle.
	a_req_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted item produced no response");

	// Only a removal reports a tag or priority.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_REMOVED |->
			rsp.removed_tag == '0 && rsp.removed_priority == '0)
		else $error("nonzero removed fields without a removal");

	// An empty report shows zero entries, a full report shows DEPTH entries.
	a_occ_edges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp.status != ST_EMPTY || rsp.occupancy == '0) &&
			(rsp.status != ST_FULL || rsp.occupancy == OCC_W'(DEPTH)))
		else $error("occupancy inconsistent with status");

endmodule

bind sorted_priority_queue spq_chk #(.DEPTH(DEPTH)) u_spq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
